@@ hw/rtl/dpb_pkg.sv @@
// Shared widths, register codes, types and helpers for the depth back-projection block.
package dpb_pkg;

  localparam int DEPTH_W       = 32;
  localparam int COORD_W       = 12;
  localparam int COLOR_W       = 8;
  localparam int INV_W         = 32;
  localparam int INV_HALF      = INV_W / 2;
  localparam int INV_FRAC_BITS = 30;
  localparam int PROD_W        = COORD_W + DEPTH_W;          // offset * depth
  localparam int PART_W        = PROD_W + INV_HALF;          // one partial product
  localparam int PART_SHIFT    = INV_FRAC_BITS - INV_HALF;
  localparam int AXMAG_W       = PART_W + 1 - PART_SHIFT;    // projected magnitude
  localparam int SQ_W          = 2 * DEPTH_W;
  localparam int SUM_W         = SQ_W + 2;
  localparam int NSTG          = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [COORD_W-1:0] CENTER_COL_RST = COORD_W'(320);
  localparam logic [COORD_W-1:0] CENTER_ROW_RST = COORD_W'(240);
  localparam logic [INV_W-1:0]   INV_FOCAL_RST  = INV_W'(3355443);
  localparam logic [DEPTH_W-1:0] DEPTH_LIM_RST  = '1;
  localparam logic [DEPTH_W-1:0] MAX_RAY_RST    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_COL = 3'd0,
    REG_CENTER_ROW = 3'd1,
    REG_INV_FOCAL  = 3'd2,
    REG_DEPTH_LIM  = 3'd3,
    REG_MAX_RAY    = 3'd4,
    REG_COLOR_EN   = 3'd5,
    REG_LABEL_EN   = 3'd6
  } cfg_reg_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] ch0;
    logic [COLOR_W-1:0] ch1;
    logic [COLOR_W-1:0] ch2;
    logic [COLOR_W-1:0] label;
  } attr_t;

  // clamp a sign/magnitude value into signed 32 bits
  function automatic logic [DEPTH_W-1:0] sat_q(input logic neg,
                                               input logic [AXMAG_W-1:0] mag);
    logic [AXMAG_W-1:0] lim;
    logic [DEPTH_W-1:0] m;
    lim = neg ? AXMAG_W'(64'h8000_0000) : AXMAG_W'(64'h7FFF_FFFF);
    m = (mag > lim) ? lim[DEPTH_W-1:0] : mag[DEPTH_W-1:0];
    sat_q = neg ? (DEPTH_W'(0) - m) : m;
  endfunction

endpackage

@@ hw/rtl/dpb_ctrl.sv @@
// Pipeline valid bits and stall-driven stage enables.
module dpb_ctrl import dpb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_stall,
  input  logic      keep,
  output pipe_ctl_t ctl,
  output logic      in_stall
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  // a stage may load when it is empty or the stage after it moves
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
    // dropped points die at the output register
    if (rdy[NSTG-1]) begin
      vld_nxt[NSTG-1] = vld_r[NSTG-2] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en   = rdy;
  assign ctl.vld  = vld_r;
  assign in_stall = !rdy[0];

endmodule

@@ hw/rtl/dpb_axis.sv @@
// One axis of the projection: offset, times depth, times reciprocal focal length.
module dpb_axis import dpb_pkg::*; (
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  logic [COORD_W-1:0] coord,
  input  logic [COORD_W-1:0] center,
  input  logic [DEPTH_W-1:0] depth_s1,
  input  logic [INV_W-1:0]   inv_focal,
  output logic               neg,
  output logic [AXMAG_W-1:0] mag
);

  logic               neg1_r, neg2_r, neg3_r, neg4_r;
  logic [COORD_W-1:0] off1_r;
  logic [PROD_W-1:0]  prod2_r;
  logic [PART_W-1:0]  hi3_r;
  logic [PART_W-1:0]  lo3_r;
  logic [AXMAG_W-1:0] mag4_r;
  logic [PART_W:0]    sum;

  assign sum = {1'b0, hi3_r} + (PART_W + 1)'(lo3_r >> INV_HALF);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      neg1_r <= coord < center;
      off1_r <= (coord < center) ? (center - coord) : (coord - center);
    end
    if (ctl.en[1]) begin
      neg2_r  <= neg1_r;
      prod2_r <= PROD_W'(off1_r) * PROD_W'(depth_s1);
    end
    // split the reciprocal in halves to keep each multiplier narrow
    if (ctl.en[2]) begin
      neg3_r <= neg2_r;
      hi3_r  <= PART_W'(prod2_r) * PART_W'(inv_focal[INV_W-1:INV_HALF]);
      lo3_r  <= PART_W'(prod2_r) * PART_W'(inv_focal[INV_HALF-1:0]);
    end
    if (ctl.en[3]) begin
      neg4_r <= neg3_r;
      mag4_r <= sum[PART_W:PART_SHIFT];
    end
  end

  assign neg = neg4_r;
  assign mag = mag4_r;

endmodule

@@ hw/rtl/dpb_ray.sv @@
// Ray length test: x^2 + y^2 + z^2 against max_ray^2 at full width.
module dpb_ray import dpb_pkg::*; (
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  logic [AXMAG_W-1:0] xm,
  input  logic [AXMAG_W-1:0] ym,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [DEPTH_W-1:0] max_ray,
  output logic               ray_ok
);

  logic              big5_r, off5_r, big6_r, off6_r;
  logic [SQ_W-1:0]   sx5_r, sy5_r, sz5_r, lim5_r;
  logic [SQ_W:0]     t6_r;
  logic [SQ_W-1:0]   sz6_r, lim6_r;
  logic [SUM_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      // a magnitude past 32 bits squares beyond any limit
      big5_r <= (|xm[AXMAG_W-1:DEPTH_W]) || (|ym[AXMAG_W-1:DEPTH_W]);
      off5_r <= max_ray == '0;
      sx5_r  <= SQ_W'(xm[DEPTH_W-1:0]) * SQ_W'(xm[DEPTH_W-1:0]);
      sy5_r  <= SQ_W'(ym[DEPTH_W-1:0]) * SQ_W'(ym[DEPTH_W-1:0]);
      sz5_r  <= SQ_W'(depth) * SQ_W'(depth);
      lim5_r <= SQ_W'(max_ray) * SQ_W'(max_ray);
    end
    if (ctl.en[5]) begin
      big6_r <= big5_r;
      off6_r <= off5_r;
      t6_r   <= (SQ_W + 1)'(sx5_r) + (SQ_W + 1)'(sy5_r);
      sz6_r  <= sz5_r;
      lim6_r <= lim5_r;
    end
  end

  assign total  = SUM_W'(t6_r) + SUM_W'(sz6_r);
  assign ray_ok = off6_r || (!big6_r && (total <= SUM_W'(lim6_r)));

endmodule

@@ hw/rtl/depth_pixel_backprojection_unit.sv @@
// Top level: pinhole back-projection of depth pixels into 3-D points.
//
// Input channel (in_*): one depth pixel per transfer, taken when in_valid is
// high and in_stall low. Output channel (out_*): one point per transfer, taken
// when out_valid is high and out_stall low. A pixel deeper than the depth
// limit, or whose ray exceeds a nonzero max_ray, produces no output transfer.
// Configuration (cfg_*): register writes by index, cfg_ready is always high;
// write only while the pipeline is empty.
//
// An input transfer reaches out_valid through the seven-stage pipeline (offset,
// offset * depth, split reciprocal products, sum, squares, square sum, output
// register). Throughput is one pixel per cycle while out_stall is low.
// When out_stall holds, stages fill behind the output register; empty
// stages still absorb input, and in_stall rises only once every stage
// holds an item. Nothing is lost or repeated across a stall.
// Reset empties the pipeline and loads the default camera registers.
module depth_pixel_backprojection_unit import dpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_W-1:0]    in_depth,
  input  logic [COORD_W-1:0]    in_column,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [COLOR_W-1:0]    in_color_ch0,
  input  logic [COLOR_W-1:0]    in_color_ch1,
  input  logic [COLOR_W-1:0]    in_color_ch2,
  input  logic [COLOR_W-1:0]    in_label,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DEPTH_W-1:0]    out_point_x,
  output logic [DEPTH_W-1:0]    out_point_y,
  output logic [DEPTH_W-1:0]    out_point_z,
  output logic [COLOR_W-1:0]    out_ch0,
  output logic [COLOR_W-1:0]    out_ch1,
  output logic [COLOR_W-1:0]    out_ch2,
  output logic [COLOR_W-1:0]    out_label,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COORD_W-1:0] center_col_r, center_row_r;
  logic [INV_W-1:0]   inv_focal_r;
  logic [DEPTH_W-1:0] depth_lim_r, max_ray_r;
  logic               color_en_r, label_en_r;

  pipe_ctl_t          ctl;
  logic               keep;
  logic               ray_ok;
  logic               xneg, yneg;
  logic [AXMAG_W-1:0] xm, ym;

  // side-band carried alongside the datapath; index k is stage k+1
  logic [DEPTH_W-1:0] depth_r [0:5];
  logic               dok_r   [0:5];
  attr_t              attr_r  [0:5];
  logic [DEPTH_W-1:0] satx_r  [0:1];
  logic [DEPTH_W-1:0] saty_r  [0:1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= CENTER_COL_RST;
      center_row_r <= CENTER_ROW_RST;
      inv_focal_r  <= INV_FOCAL_RST;
      depth_lim_r  <= DEPTH_LIM_RST;
      max_ray_r    <= MAX_RAY_RST;
      color_en_r   <= 1'b0;
      label_en_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_COL: center_col_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_ROW: center_row_r <= cfg_data[COORD_W-1:0];
        REG_INV_FOCAL:  inv_focal_r  <= cfg_data[INV_W-1:0];
        REG_DEPTH_LIM:  depth_lim_r  <= cfg_data[DEPTH_W-1:0];
        REG_MAX_RAY:    max_ray_r    <= cfg_data[DEPTH_W-1:0];
        REG_COLOR_EN:   color_en_r   <= cfg_data[0];
        REG_LABEL_EN:   label_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .keep      (keep),
    .ctl       (ctl),
    .in_stall  (in_stall)
  );

  dpb_axis u_axis_x (
    .clk       (clk),
    .ctl       (ctl),
    .coord     (in_column),
    .center    (center_col_r),
    .depth_s1  (depth_r[0]),
    .inv_focal (inv_focal_r),
    .neg       (xneg),
    .mag       (xm)
  );

  dpb_axis u_axis_y (
    .clk       (clk),
    .ctl       (ctl),
    .coord     (in_row),
    .center    (center_row_r),
    .depth_s1  (depth_r[0]),
    .inv_focal (inv_focal_r),
    .neg       (yneg),
    .mag       (ym)
  );

  dpb_ray u_ray (
    .clk     (clk),
    .ctl     (ctl),
    .xm      (xm),
    .ym      (ym),
    .depth   (depth_r[3]),
    .max_ray (max_ray_r),
    .ray_ok  (ray_ok)
  );

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      depth_r[0]      <= in_depth;
      dok_r[0]        <= in_depth <= depth_lim_r;
      attr_r[0].ch0   <= in_color_ch0;
      attr_r[0].ch1   <= in_color_ch1;
      attr_r[0].ch2   <= in_color_ch2;
      attr_r[0].label <= in_label;
    end
    for (int k = 1; k < 6; k++) begin
      if (ctl.en[k]) begin
        depth_r[k] <= depth_r[k-1];
        dok_r[k]   <= dok_r[k-1];
        attr_r[k]  <= attr_r[k-1];
      end
    end
    if (ctl.en[4]) begin
      satx_r[0] <= sat_q(xneg, xm);
      saty_r[0] <= sat_q(yneg, ym);
    end
    if (ctl.en[5]) begin
      satx_r[1] <= satx_r[0];
      saty_r[1] <= saty_r[0];
    end
    if (ctl.en[6]) begin
      out_point_x <= satx_r[1];
      out_point_y <= saty_r[1];
      out_point_z <= depth_r[5];
      out_ch0     <= color_en_r ? attr_r[5].ch0 : '0;
      out_ch1     <= color_en_r ? attr_r[5].ch1 : '0;
      out_ch2     <= color_en_r ? attr_r[5].ch2 : '0;
      out_label   <= label_en_r ? attr_r[5].label : '0;
    end
  end

  assign keep      = dok_r[5] && ray_ok;
  assign out_valid = ctl.vld[NSTG-1];

  // a delivered point never breaks the depth limit
  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_z <= depth_lim_r)
    else $error("point beyond depth limit delivered");

  // input backpressure only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&ctl.vld)))
    else $error("input stalled with room in pipeline");

  // colour disabled gives zero channels
  a_color_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !color_en_r) |-> (out_ch0 == '0 && out_ch1 == '0 && out_ch2 == '0))
    else $error("colour leaked while disabled");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the depth back-projection unit: directed and random pixels checked against a point predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpb_pkg::*;

  localparam int PIPE_LAT    = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT    = 31;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] ch0, ch1, ch2, label;
  } pixel_t;

  typedef struct {
    logic [DEPTH_W-1:0] x, y, z;
    logic [COLOR_W-1:0] ch0, ch1, ch2, label;
  } point_t;

  typedef struct {
    logic [COORD_W-1:0] center_col, center_row;
    logic [INV_W-1:0]   inv_focal;
    logic [DEPTH_W-1:0] depth_lim, max_ray;
    logic               color_en, label_en;
  } camera_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DEPTH_W-1:0]    in_depth = '0;
  logic [COORD_W-1:0]    in_column = '0;
  logic [COORD_W-1:0]    in_row = '0;
  logic [COLOR_W-1:0]    in_color_ch0 = '0;
  logic [COLOR_W-1:0]    in_color_ch1 = '0;
  logic [COLOR_W-1:0]    in_color_ch2 = '0;
  logic [COLOR_W-1:0]    in_label = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DEPTH_W-1:0]    out_point_x, out_point_y, out_point_z;
  logic [COLOR_W-1:0]    out_ch0, out_ch1, out_ch2, out_label;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_t  pixels_todo[$];
  point_t  points_due[$];
  pixel_t  bus_pix;
  camera_t cam;
  int      idle_pct = IDLE_PCT;
  int      mismatches = 0;
  int      cycles = 0;
  int      hold_req = 0;
  int      hold_taken = 0;
  int      hold_left = 0;

  depth_pixel_backprojection_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_depth     (in_depth),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_color_ch0 (in_color_ch0),
    .in_color_ch1 (in_color_ch1),
    .in_color_ch2 (in_color_ch2),
    .in_label     (in_label),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_point_x  (out_point_x),
    .out_point_y  (out_point_y),
    .out_point_z  (out_point_z),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_label    (out_label),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign bus_pix = {in_depth, in_column, in_row, in_color_ch0, in_color_ch1, in_color_ch2,
                    in_label};

  // exact floor(off * depth * inv_focal / 2^30)
  function automatic logic [63:0] axis_mag(input logic [COORD_W:0] off,
                                           input logic [DEPTH_W-1:0] d);
    logic [127:0] prod;
    prod = 128'(off) * 128'(d) * 128'(cam.inv_focal);
    return prod[93:30];
  endfunction

  function automatic logic [DEPTH_W-1:0] clamp_axis(input bit neg, input logic [63:0] mag);
    if (neg) begin
      return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'h0 - mag[31:0];
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // returns 1 when the pixel yields a point
  function automatic bit project_pixel(input pixel_t p, output point_t pt);
    bit                 xneg, yneg;
    logic [COORD_W:0]   xoff, yoff;
    logic [63:0]        xm, ym;
    logic [127:0]       ray2, lim2;
    pt = '{default: '0};
    if (p.depth > cam.depth_lim) return 0;
    xneg = p.col < cam.center_col;
    yneg = p.row < cam.center_row;
    xoff = xneg ? {1'b0, cam.center_col - p.col} : {1'b0, p.col - cam.center_col};
    yoff = yneg ? {1'b0, cam.center_row - p.row} : {1'b0, p.row - cam.center_row};
    xm = axis_mag(xoff, p.depth);
    ym = axis_mag(yoff, p.depth);
    // ray test uses the unclamped axes at full width
    ray2 = 128'(xm) * 128'(xm) + 128'(ym) * 128'(ym) + 128'(p.depth) * 128'(p.depth);
    lim2 = 128'(cam.max_ray) * 128'(cam.max_ray);
    if (cam.max_ray != '0 && ray2 > lim2) return 0;
    pt.x     = clamp_axis(xneg, xm);
    pt.y     = clamp_axis(yneg, ym);
    pt.z     = p.depth;
    pt.ch0   = cam.color_en ? p.ch0 : '0;
    pt.ch1   = cam.color_en ? p.ch1 : '0;
    pt.ch2   = cam.color_en ? p.ch2 : '0;
    pt.label = cam.label_en ? p.label : '0;
    return 1;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      end
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    pixel_t nxt;
    point_t pt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (project_pixel(bus_pix, pt)) points_due.insert(points_due.size(), pt);
      end
      if (!in_valid || !in_stall) begin
        if (pixels_todo.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pixels_todo[0];
          pixels_todo.delete(0);
          {in_depth, in_column, in_row, in_color_ch0, in_color_ch1, in_color_ch2,
           in_label} <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // point monitor and receiver backpressure
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected point x=%h y=%h z=%h", $time, out_point_x,
                     out_point_y, out_point_z);
          end
        end else begin
          want = points_due[0];
          points_due.delete(0);
          check_field("point_x", want.x, out_point_x);
          check_field("point_y", want.y, out_point_y);
          check_field("point_z", want.z, out_point_z);
          check_field("ch0", 32'(want.ch0), 32'(out_ch0));
          check_field("ch1", 32'(want.ch1), 32'(out_ch1));
          check_field("ch2", 32'(want.ch2), 32'(out_ch2));
          check_field("label", 32'(want.label), 32'(out_label));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_COL: cam.center_col = val[COORD_W-1:0];
      REG_CENTER_ROW: cam.center_row = val[COORD_W-1:0];
      REG_INV_FOCAL:  cam.inv_focal  = val;
      REG_DEPTH_LIM:  cam.depth_lim  = val;
      REG_MAX_RAY:    cam.max_ray    = val;
      REG_COLOR_EN:   cam.color_en   = val[0];
      REG_LABEL_EN:   cam.label_en   = val[0];
      default: ;
    endcase
  endtask

  task automatic write_camera(input logic [11:0] ccol, input logic [11:0] crow,
                              input logic [31:0] inv, input logic [31:0] mdepth,
                              input logic [31:0] mray, input bit col_en, input bit lab_en);
    write_reg(REG_CENTER_COL, 32'(ccol));
    write_reg(REG_CENTER_ROW, 32'(crow));
    write_reg(REG_INV_FOCAL, inv);
    write_reg(REG_DEPTH_LIM, mdepth);
    write_reg(REG_MAX_RAY, mray);
    write_reg(REG_COLOR_EN, 32'(col_en));
    write_reg(REG_LABEL_EN, 32'(lab_en));
  endtask

  // sender stays quiet until the pipeline has drained
  task automatic wait_idle();
    do @(negedge clk); while (pixels_todo.size() != 0 || in_valid || points_due.size() != 0);
    repeat (PIPE_LAT + 3) @(negedge clk);
  endtask

  task automatic queue_pixel(input logic [31:0] d, input logic [11:0] c, input logic [11:0] r,
                             input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                             input logic [7:0] lab);
    pixel_t p;
    p = '{d, c, r, c0, c1, c2, lab};
    pixels_todo.insert(pixels_todo.size(), p);
  endtask

  function automatic logic [11:0] pick_center();
    case ($urandom_range(4))
      0:       return 12'd0;
      1:       return 12'd2048;
      default: return 12'($urandom_range(2048));
    endcase
  endfunction

  initial begin
    logic [31:0] inv, mdepth, mray, d;
    cam = '{12'd320, 12'd240, 32'd3355443, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset camera: centre pixel, corners, saturation and ray limit at its edge
    queue_pixel(32'h0, 12'd320, 12'd240, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(32'h0001_0000, 12'd0, 12'd0, 8'hAA, 8'h55, 8'h0F, 8'hF0);
    queue_pixel(32'h1000_0000, 12'd4095, 12'd240, 8'h12, 8'h34, 8'h56, 8'h78);
    queue_pixel(32'hFFFF_FFFF, 12'd320, 12'd240, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(32'hFFFF_FFFF, 12'd321, 12'd240, 8'h01, 8'h02, 8'h03, 8'h04);
    queue_pixel(32'h1000_0000, 12'd0, 12'd240, 8'h80, 8'h40, 8'h20, 8'h10);
    queue_pixel(32'h2000_0000, 12'd4095, 12'd4095, 8'h11, 8'h22, 8'h33, 8'h44);
    wait_idle();

    // off-centre extremes, depth limit, no ray check, attributes on
    write_camera(12'd2048, 12'd2048, 32'hFFFF_FFFF, 32'h0010_0000, 32'h0, 1'b1, 1'b1);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    @(negedge clk);
    queue_pixel(32'h0010_0000, 12'd0, 12'd4095, 8'hFF, 8'h00, 8'hFF, 8'h00);
    queue_pixel(32'h0010_0001, 12'd1, 12'd1, 8'h01, 8'h01, 8'h01, 8'h01);
    queue_pixel(32'h0, 12'd0, 12'd0, 8'h00, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(32'h1, 12'd2048, 12'd2047, 8'hC3, 8'h3C, 8'h99, 8'h66);
    queue_pixel(32'h0000_8000, 12'd4095, 12'd0, 8'h00, 8'h00, 8'h00, 8'h5A);
    wait_idle();

    // zero depth limit, then ray limit exactly at 1.0 with zero reciprocal
    write_camera(12'd0, 12'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 1'b1);
    @(negedge clk);
    queue_pixel(32'h0, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF, 8'hA5);
    queue_pixel(32'h1, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hA5);
    wait_idle();
    write_reg(REG_DEPTH_LIM, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_pixel(32'h0001_0000, 12'd4095, 12'd4095, 8'h7E, 8'h7E, 8'h7E, 8'h81);
    queue_pixel(32'h0001_0001, 12'd4095, 12'd4095, 8'h7E, 8'h7E, 8'h7E, 8'h81);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      inv = ($urandom_range(3) == 0) ? $urandom
                                     : 32'((64'd1 << 30) / $urandom_range(100, 2000));
      mdepth = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF
                                        : $urandom_range(32'h0100_0000, 32'h0001_0000);
      case ($urandom_range(2))
        0:       mray = 32'h0;
        1:       mray = 32'hFFFF_FFFF;
        default: mray = $urandom_range(32'h4000_0000, 32'h0010_0000);
      endcase
      write_camera(pick_center(), pick_center(), inv, mdepth, mray,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      @(negedge clk);
      idle_pct = (ph == 3) ? 0 : IDLE_PCT;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        d = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0100_0000);
        queue_pixel(d, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      // long receiver hold-off against a sender that never idles: fills the pipeline
      if (ph == 3) hold_req++;
      wait_idle();
    end

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_ctrl.sv
hw/rtl/dpb_axis.sv
hw/rtl/dpb_ray.sv
hw/rtl/depth_pixel_backprojection_unit.sv
sim/tb_top.sv
